### design/psb_pkg.sv
// shared constants, register indexes and colour table of the sprite blitter
package psb_pkg;

   localparam int CODE_W       = 8;
   localparam int COLOR_W      = 16;
   localparam int ADDR_OUT_W   = 17;
   localparam int RSP_DATA_W   = 40;
   localparam int CSR_IDX_W    = 3;
   localparam int CSR_DATA_W   = 9;
   localparam int ORIGIN_X_W   = 9;
   localparam int ORIGIN_Y_W   = 8;
   localparam int SIZE_W       = 8;
   localparam int SCALE_W      = 4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_ORIGIN_X      = 3'd0,
      CSR_ORIGIN_Y      = 3'd1,
      CSR_SPRITE_WIDTH  = 3'd2,
      CSR_SPRITE_HEIGHT = 3'd3,
      CSR_SCALE         = 3'd4
   } csr_index_type;

   function automatic logic [COLOR_W-1:0] map_color(input logic [CODE_W-1:0] code);
      logic [COLOR_W-1:0] color;
      case (code)
         8'h3C:   color = 16'h0000;
         8'hE0:   color = 16'h00F8;
         8'hFF:   color = 16'hFFFF;
         8'h03:   color = 16'h1C00;
         8'h13:   color = 16'h1F04;
         8'hA0:   color = 16'h00A0;
         8'hF6:   color = 16'h51E5;
         8'hAD:   color = 16'hCBAB;
         8'h29:   color = 16'h492A;
         8'h4D:   color = 16'h492A;
         8'hDF:   color = 16'h5DCF;
         8'hD0:   color = 16'hC4DC;
         8'h60:   color = 16'h0078;
         8'h6D:   color = 16'hCF7B;
         8'h04:   color = 16'h0000;
         default: color = {{(COLOR_W-CODE_W){1'b0}}, code};
      endcase
      return color;
   endfunction

endpackage

### design/palette_sprite_scaler_blit_top.sv
// top level of the palette sprite scaler blitter
//
// req_ takes one 8-bit sprite code per item, column by column with rows
// running top to bottom inside each column. every code is turned into
// scale x scale framebuffer writes on rsp_, row of the block outer and
// column inner; rsp_tlast marks the final write of a code and rsp_tuser
// flags an address at or past the end of the frame. a code with scale 0
// gives no writes but still moves the position.
// csr_ writes origin, sprite size and scale; write them only while idle.
// the output gives one write per cycle while rsp_tready is high; a code
// gives scale*scale writes (4 at scale 2). the front end takes a code
// every cycle while req_tready is high; a four-entry queue holds codes
// ahead of the write walker, whose output register drives rsp_tvalid.
// reset clears the position, the queue and the output register and loads
// the register reset values. when rsp_tready is low the output holds and
// the queue fills, after which req_tready drops.
module palette_sprite_scaler_blit_top #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 240,
   parameter int MAX_SCALE    = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_we,
   input  logic [psb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [psb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [psb_pkg::CODE_W-1:0]        req_tdata,   // [7:0] pixel_code
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [16:0] pixel_address, [32:17] pixel_color
   output logic [psb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tuser    // [0] off_frame
);

   localparam int MAX_ADDR = (255 + 255 * MAX_SCALE + MAX_SCALE - 1) * FRAME_WIDTH
                             + 511 + 255 * MAX_SCALE + MAX_SCALE - 1;
   localparam int LIMIT    = FRAME_WIDTH * FRAME_HEIGHT;
   localparam int SPAN     = (MAX_ADDR > LIMIT) ? MAX_ADDR : LIMIT;
   localparam int SPAN_W   = $clog2(SPAN + 1);
   localparam int ADDR_W   = (SPAN_W > psb_pkg::ADDR_OUT_W) ? SPAN_W : psb_pkg::ADDR_OUT_W;
   localparam int SX_W     = (MAX_SCALE > 1) ? $clog2(MAX_SCALE) : 1;
   localparam int Q_W      = psb_pkg::COLOR_W + ADDR_W + SX_W;
   localparam int Q_DEPTH  = 4;

   logic                          f_valid;
   logic                          f_ready;
   logic [psb_pkg::COLOR_W-1:0]   f_color;
   logic [ADDR_W-1:0]             f_start;
   logic [SX_W-1:0]               f_lidx;
   logic                          q_valid;
   logic                          q_ready;
   logic [Q_W-1:0]                q_data;

   psb_front #(
      .FRAME_WIDTH (FRAME_WIDTH),
      .MAX_SCALE   (MAX_SCALE),
      .ADDR_W      (ADDR_W),
      .SX_W        (SX_W)
   ) u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .out_valid    (f_valid),
      .out_ready    (f_ready),
      .out_color    (f_color),
      .out_start    (f_start),
      .out_last_idx (f_lidx)
   );

   psb_fifo #(
      .WIDTH (Q_W),
      .DEPTH (Q_DEPTH)
   ) u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  ({f_color, f_start, f_lidx}),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_data)
   );

   psb_back #(
      .FRAME_WIDTH  (FRAME_WIDTH),
      .FRAME_HEIGHT (FRAME_HEIGHT),
      .ADDR_W       (ADDR_W),
      .SX_W         (SX_W)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_color    (q_data[Q_W-1 -: psb_pkg::COLOR_W]),
      .q_start    (q_data[SX_W +: ADDR_W]),
      .q_last_idx (q_data[SX_W-1:0]),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

### design/psb_front.sv
// front end: config registers, sprite position, colour lookup and start address
module psb_front #(
   parameter int FRAME_WIDTH = 320,
   parameter int MAX_SCALE   = 8,
   parameter int ADDR_W      = 24,
   parameter int SX_W        = 3
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [psb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [psb_pkg::CSR_DATA_W-1:0]       csr_wdata,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [psb_pkg::CODE_W-1:0]           req_tdata,
   output logic                                 out_valid,
   input  logic                                 out_ready,
   output logic [psb_pkg::COLOR_W-1:0]          out_color,
   output logic [ADDR_W-1:0]                    out_start,
   output logic [SX_W-1:0]                      out_last_idx
);

   localparam int S_W   = $clog2(MAX_SCALE + 1);
   localparam int BX_W  = $clog2(511 + 255 * MAX_SCALE + 1);
   localparam int BY_W  = $clog2(255 + 255 * MAX_SCALE + 1);
   localparam int FW_W  = $clog2(FRAME_WIDTH + 1);
   localparam int PM_W  = psb_pkg::SIZE_W + S_W;
   localparam logic [FW_W-1:0] FW_C = FW_W'(FRAME_WIDTH);

   logic [psb_pkg::ORIGIN_X_W-1:0] origin_x_ff, origin_x_in;
   logic [psb_pkg::ORIGIN_Y_W-1:0] origin_y_ff, origin_y_in;
   logic [psb_pkg::SIZE_W-1:0]     width_ff, width_in;
   logic [psb_pkg::SIZE_W-1:0]     height_ff, height_in;
   logic [psb_pkg::SCALE_W-1:0]    scale_ff, scale_in;
   logic [psb_pkg::SIZE_W-1:0]     col_ff, col_in;
   logic [psb_pkg::SIZE_W-1:0]     row_ff, row_in;

   logic                           s1_valid_ff, s1_valid_in;
   logic [psb_pkg::COLOR_W-1:0]    s1_color_ff, s1_color_in;
   logic [BX_W-1:0]                s1_bx_ff, s1_bx_in;
   logic [BY_W-1:0]                s1_by_ff, s1_by_in;
   logic [SX_W-1:0]                s1_lidx_ff, s1_lidx_in;

   logic                           accept;
   logic [S_W-1:0]                 s_sat;
   logic [PM_W-1:0]                col_prod;
   logic [PM_W-1:0]                row_prod;
   logic [BY_W+FW_W-1:0]           line_prod;
   logic                           row_wrap;
   logic                           col_wrap;

   assign req_tready   = !s1_valid_ff || out_ready;
   assign accept       = req_tvalid && req_tready;
   assign s_sat        = (scale_ff > psb_pkg::SCALE_W'(MAX_SCALE)) ? S_W'(MAX_SCALE)
                                                                   : S_W'(scale_ff);
   assign col_prod     = PM_W'(col_ff) * PM_W'(s_sat);
   assign row_prod     = PM_W'(row_ff) * PM_W'(s_sat);
   assign row_wrap     = ({1'b0, row_ff} + 9'd1) >= {1'b0, height_ff};
   assign col_wrap     = ({1'b0, col_ff} + 9'd1) >= {1'b0, width_ff};

   assign line_prod    = (BY_W+FW_W)'(s1_by_ff) * (BY_W+FW_W)'(FW_C);
   assign out_valid    = s1_valid_ff;
   assign out_color    = s1_color_ff;
   assign out_start    = ADDR_W'(line_prod) + ADDR_W'(s1_bx_ff);
   assign out_last_idx = s1_lidx_ff;

   always_comb begin
      origin_x_in = origin_x_ff;
      origin_y_in = origin_y_ff;
      width_in    = width_ff;
      height_in   = height_ff;
      scale_in    = scale_ff;
      if (csr_we) begin
         case (csr_index)
            psb_pkg::CSR_ORIGIN_X:      origin_x_in = csr_wdata;
            psb_pkg::CSR_ORIGIN_Y:      origin_y_in = csr_wdata[psb_pkg::ORIGIN_Y_W-1:0];
            psb_pkg::CSR_SPRITE_WIDTH:  width_in    = csr_wdata[psb_pkg::SIZE_W-1:0];
            psb_pkg::CSR_SPRITE_HEIGHT: height_in   = csr_wdata[psb_pkg::SIZE_W-1:0];
            psb_pkg::CSR_SCALE:         scale_in    = csr_wdata[psb_pkg::SCALE_W-1:0];
            default: ;
         endcase
      end

      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (row_wrap) begin
            row_in = '0;
            col_in = col_wrap ? '0 : col_ff + 8'd1;
         end else begin
            row_in = row_ff + 8'd1;
         end
      end

      s1_valid_in = s1_valid_ff;
      s1_color_in = s1_color_ff;
      s1_bx_in    = s1_bx_ff;
      s1_by_in    = s1_by_ff;
      s1_lidx_in  = s1_lidx_ff;
      if (accept) begin
         s1_valid_in = (s_sat != '0);
         s1_color_in = psb_pkg::map_color(req_tdata);
         s1_bx_in    = BX_W'(origin_x_ff) + BX_W'(col_prod);
         s1_by_in    = BY_W'(origin_y_ff) + BY_W'(row_prod);
         s1_lidx_in  = SX_W'(s_sat - S_W'(1));
      end else if (out_ready) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         width_ff    <= 8'd1;
         height_ff   <= 8'd1;
         scale_ff    <= 4'd1;
         col_ff      <= '0;
         row_ff      <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         origin_x_ff <= origin_x_in;
         origin_y_ff <= origin_y_in;
         width_ff    <= width_in;
         height_ff   <= height_in;
         scale_ff    <= scale_in;
         col_ff      <= col_in;
         row_ff      <= row_in;
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_color_ff <= s1_color_in;
      s1_bx_ff    <= s1_bx_in;
      s1_by_ff    <= s1_by_in;
      s1_lidx_ff  <= s1_lidx_in;
   end

endmodule

### design/psb_fifo.sv
// small flip-flop queue between front end and write generator
module psb_fifo #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  logic [WIDTH-1:0] push_data,
   output logic             pop_valid,
   input  logic             pop_ready,
   output logic [WIDTH-1:0] pop_data
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### design/psb_back.sv
// write generator: walks the scale x scale block and drives the output register
module psb_back #(
   parameter int FRAME_WIDTH  = 320,
   parameter int FRAME_HEIGHT = 240,
   parameter int ADDR_W       = 24,
   parameter int SX_W         = 3
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              q_valid,
   output logic                              q_ready,
   input  logic [psb_pkg::COLOR_W-1:0]       q_color,
   input  logic [ADDR_W-1:0]                 q_start,
   input  logic [SX_W-1:0]                   q_last_idx,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [psb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic                              rsp_tlast,
   output logic                              rsp_tuser
);

   localparam logic [ADDR_W-1:0] LIMIT_C = ADDR_W'(FRAME_WIDTH * FRAME_HEIGHT);
   localparam logic [ADDR_W-1:0] FW_C    = ADDR_W'(FRAME_WIDTH);

   logic                                busy_ff, busy_in;
   logic [ADDR_W-1:0]                   line_ff, line_in;
   logic [SX_W-1:0]                     sx_ff, sx_in;
   logic [SX_W-1:0]                     sy_ff, sy_in;
   logic [SX_W-1:0]                     lidx_ff, lidx_in;
   logic [psb_pkg::COLOR_W-1:0]         color_ff, color_in;

   logic                                out_valid_ff, out_valid_in;
   logic [psb_pkg::ADDR_OUT_W-1:0]      out_addr_ff, out_addr_in;
   logic [psb_pkg::COLOR_W-1:0]         out_color_ff, out_color_in;
   logic                                out_off_ff, out_off_in;
   logic                                out_last_ff, out_last_in;

   logic                                out_free;
   logic                                step;
   logic                                last;
   logic                                pop;
   logic [ADDR_W-1:0]                   cur_addr;

   assign out_free = !out_valid_ff || rsp_tready;
   assign step     = busy_ff && out_free;
   assign last     = (sx_ff == lidx_ff) && (sy_ff == lidx_ff);
   assign pop      = q_valid && (!busy_ff || (step && last));
   assign q_ready  = pop;
   assign cur_addr = line_ff + ADDR_W'(sx_ff);

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(psb_pkg::RSP_DATA_W - psb_pkg::ADDR_OUT_W - psb_pkg::COLOR_W){1'b0}},
                        out_color_ff, out_addr_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_off_ff;

   always_comb begin
      busy_in  = busy_ff;
      line_in  = line_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      lidx_in  = lidx_ff;
      color_in = color_ff;
      if (pop) begin
         busy_in  = 1'b1;
         line_in  = q_start;
         sx_in    = '0;
         sy_in    = '0;
         lidx_in  = q_last_idx;
         color_in = q_color;
      end else if (step && last) begin
         busy_in = 1'b0;
      end else if (step) begin
         if (sx_ff == lidx_ff) begin
            sx_in   = '0;
            sy_in   = sy_ff + SX_W'(1);
            line_in = line_ff + FW_C;
         end else begin
            sx_in = sx_ff + SX_W'(1);
         end
      end

      out_valid_in = out_valid_ff;
      out_addr_in  = out_addr_ff;
      out_color_in = out_color_ff;
      out_off_in   = out_off_ff;
      out_last_in  = out_last_ff;
      if (step) begin
         out_valid_in = 1'b1;
         out_addr_in  = cur_addr[psb_pkg::ADDR_OUT_W-1:0];
         out_color_in = color_ff;
         out_off_in   = (cur_addr >= LIMIT_C);
         out_last_in  = last;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      line_ff      <= line_in;
      sx_ff        <= sx_in;
      sy_ff        <= sy_in;
      lidx_ff      <= lidx_in;
      color_ff     <= color_in;
      out_addr_ff  <= out_addr_in;
      out_color_ff <= out_color_in;
      out_off_ff   <= out_off_in;
      out_last_ff  <= out_last_in;
   end

endmodule

### design/psb_checker.sv
// port-level checks of the sprite blitter and their binding
module psb_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              csr_we,
   input logic [psb_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [psb_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input logic                              req_tvalid,
   input logic                              req_tready,
   input logic [psb_pkg::CODE_W-1:0]        req_tdata,
   input logic                              rsp_tvalid,
   input logic                              rsp_tready,
   input logic [psb_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                              rsp_tlast,
   input logic                              rsp_tuser
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("result item dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=>
         $stable(rsp_tdata) && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result item changed");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item shown right after reset");

   a_reset_ready: assert property (@(posedge clock)
      reset |=> req_tready)
      else $error("input not ready right after reset");

endmodule

bind palette_sprite_scaler_blit_top psb_checker u_psb_checker (.*);

### verif/testbench.sv
// self-checking testbench for the palette sprite scaler blitter
module testbench;

   localparam int CODE_W         = psb_pkg::CODE_W;
   localparam int COLOR_W        = psb_pkg::COLOR_W;
   localparam int ADDR_OUT_W     = psb_pkg::ADDR_OUT_W;
   localparam int RSP_DATA_W     = psb_pkg::RSP_DATA_W;
   localparam int CSR_IDX_W      = psb_pkg::CSR_IDX_W;
   localparam int CSR_DATA_W     = psb_pkg::CSR_DATA_W;
   localparam int ORIGIN_X_W     = psb_pkg::ORIGIN_X_W;
   localparam int ORIGIN_Y_W     = psb_pkg::ORIGIN_Y_W;
   localparam int SIZE_W         = psb_pkg::SIZE_W;
   localparam int SCALE_W        = psb_pkg::SCALE_W;

   localparam int FRAME_W        = 320;
   localparam int FRAME_H        = 240;
   localparam int SCALE_CAP      = 8;
   localparam int SETTLE_CYCLES  = 24;
   localparam int QUIET_LIMIT    = 4000;
   localparam int HOLD_OFF_LONG  = 300;
   localparam int PHASE_ITEMS    = 25;
   localparam int RANDOM_PHASES  = 12;

   typedef struct packed {
      logic [ADDR_OUT_W-1:0] address;
      logic [COLOR_W-1:0]    color;
      logic                  off_frame;
      logic                  run_last;
   } fb_write_type;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_IDX_W-1:0]   csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [CODE_W-1:0]      req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tuser;

   // sprite blitter state as predicted
   logic [ORIGIN_X_W-1:0]  reg_origin_x;
   logic [ORIGIN_Y_W-1:0]  reg_origin_y;
   logic [SIZE_W-1:0]      reg_width;
   logic [SIZE_W-1:0]      reg_height;
   logic [SCALE_W-1:0]     reg_scale;
   int unsigned            cur_column;
   int unsigned            cur_row;
   fb_write_type           pending_writes[$];

   logic [CODE_W-1:0]  palette_keys [0:14] = '{
      8'h3C, 8'hE0, 8'hFF, 8'h03, 8'h13, 8'hA0, 8'hF6, 8'hAD,
      8'h29, 8'h4D, 8'hDF, 8'hD0, 8'h60, 8'h6D, 8'h04};
   logic [COLOR_W-1:0] palette_colours [0:14] = '{
      16'h0000, 16'h00F8, 16'hFFFF, 16'h1C00, 16'h1F04, 16'h00A0, 16'h51E5, 16'hCBAB,
      16'h492A, 16'h492A, 16'h5DCF, 16'hC4DC, 16'h0078, 16'hCF7B, 16'h0000};

   int sender_idle_pct;
   int receiver_stall_pct;
   int hold_off_left;
   int errors;
   int quiet_cycles;
   int codes_sent;
   int writes_checked;
   int off_frame_writes;
   int wrapped_addresses;
   int blank_codes;

   palette_sprite_scaler_blit_top DUT (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   function automatic logic [COLOR_W-1:0] colour_of(input logic [CODE_W-1:0] code);
      logic [COLOR_W-1:0] colour;
      colour = {{(COLOR_W-CODE_W){1'b0}}, code};
      for (int i = 0; i < 15; i++)
         if (palette_keys[i] == code) colour = palette_colours[i];
      return colour;
   endfunction

   function automatic void predict_writes(input logic [CODE_W-1:0] code);
      int unsigned  s;
      int unsigned  base_x;
      int unsigned  base_y;
      int unsigned  addr;
      fb_write_type w;
      s = (reg_scale > SCALE_CAP) ? SCALE_CAP : reg_scale;
      base_x = reg_origin_x + cur_column * s;
      base_y = reg_origin_y + cur_row * s;
      if (s == 0) blank_codes++;
      for (int unsigned sy = 0; sy < s; sy++) begin
         for (int unsigned sx = 0; sx < s; sx++) begin
            addr = (base_y + sy) * FRAME_W + base_x + sx;
            w.address   = addr[ADDR_OUT_W-1:0];
            w.color     = colour_of(code);
            w.off_frame = (addr >= FRAME_W * FRAME_H);
            w.run_last  = (sy + 1 == s) && (sx + 1 == s);
            if (w.off_frame) off_frame_writes++;
            if (addr >= (1 << ADDR_OUT_W)) wrapped_addresses++;
            pending_writes.push_back(w);
         end
      end
      if (cur_row + 1 >= reg_height) begin
         cur_row = 0;
         if (cur_column + 1 >= reg_width) cur_column = 0;
         else cur_column = (cur_column + 1) & 8'hFF;
      end else begin
         cur_row = (cur_row + 1) & 8'hFF;
      end
   endfunction

   task automatic report_mismatch(input string what, input int unsigned want,
                                  input int unsigned got);
      $display("mismatch %s: expected %0h, got %0h at %0t", what, want, got, $time);
      errors++;
   endtask

   // result checker
   always @(posedge clock) begin
      fb_write_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            report_mismatch("unexpected write, address", 0, rsp_tdata[ADDR_OUT_W-1:0]);
         end else begin
            want = pending_writes.pop_front();
            writes_checked++;
            if (rsp_tdata[ADDR_OUT_W-1:0] !== want.address)
               report_mismatch("pixel_address", want.address, rsp_tdata[ADDR_OUT_W-1:0]);
            if (rsp_tdata[ADDR_OUT_W+COLOR_W-1:ADDR_OUT_W] !== want.color)
               report_mismatch("pixel_color", want.color,
                               rsp_tdata[ADDR_OUT_W+COLOR_W-1:ADDR_OUT_W]);
            if (rsp_tuser !== want.off_frame)
               report_mismatch("off_frame", want.off_frame, rsp_tuser);
            if (rsp_tlast !== want.run_last)
               report_mismatch("run_last", want.run_last, rsp_tlast);
         end
      end
   end

   // receiver side: random stalls plus an optional long hold-off
   initial begin
      forever begin
         @(negedge clock);
         if (hold_off_left > 0) begin
            rsp_tready = 1'b0;
            hold_off_left--;
         end else begin
            rsp_tready = ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("watchdog: no progress for %0d cycles", QUIET_LIMIT);
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_code(input logic [CODE_W-1:0] code);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid = 1'b0;
         req_tdata  = CODE_W'($urandom_range(255));
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = code;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_writes(code);
      codes_sent++;
      @(negedge clock);
   endtask

   task automatic wait_drained();
      req_tvalid = 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
   endtask

   task automatic wait_idle();
      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_reg(input int idx, input int value);
      csr_we    = 1'b1;
      csr_index = CSR_IDX_W'(idx);
      csr_wdata = CSR_DATA_W'(value);
      case (csr_index)
         psb_pkg::CSR_ORIGIN_X:      reg_origin_x = csr_wdata[ORIGIN_X_W-1:0];
         psb_pkg::CSR_ORIGIN_Y:      reg_origin_y = csr_wdata[ORIGIN_Y_W-1:0];
         psb_pkg::CSR_SPRITE_WIDTH:  reg_width    = csr_wdata[SIZE_W-1:0];
         psb_pkg::CSR_SPRITE_HEIGHT: reg_height   = csr_wdata[SIZE_W-1:0];
         psb_pkg::CSR_SCALE:         reg_scale    = csr_wdata[SCALE_W-1:0];
         default: ;
      endcase
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   task automatic set_sprite(input int ox, input int oy, input int w, input int h, input int s);
      wait_idle();
      write_reg(psb_pkg::CSR_ORIGIN_X, ox);
      write_reg(psb_pkg::CSR_ORIGIN_Y, oy);
      write_reg(psb_pkg::CSR_SPRITE_WIDTH, w);
      write_reg(psb_pkg::CSR_SPRITE_HEIGHT, h);
      write_reg(psb_pkg::CSR_SCALE, s);
   endtask

   function automatic logic [CODE_W-1:0] pick_code();
      if ($urandom_range(2) == 0) return palette_keys[$urandom_range(14)];
      return CODE_W'($urandom_range(255));
   endfunction

   function automatic int pick_size();
      int r;
      r = $urandom_range(11);
      if (r == 0) return 0;
      if (r == 1) return 255;
      return $urandom_range(1, 6);
   endfunction

   // random sprite set-up; unused high bits of narrow registers get noise
   task automatic randomise_sprite();
      int r;
      int s;
      r = $urandom_range(19);
      if (r == 0) s = 0;
      else if (r == 1) s = $urandom_range(9, 15);
      else if (r < 4) s = $urandom_range(4, 8);
      else s = $urandom_range(1, 3);
      r = $urandom_range(9);
      wait_idle();
      write_reg(psb_pkg::CSR_ORIGIN_X, (r == 0) ? 0 : (r == 1) ? 319 : $urandom_range(319));
      r = $urandom_range(9);
      write_reg(psb_pkg::CSR_ORIGIN_Y, ((r == 0) ? 0 : (r == 1) ? 239 : $urandom_range(239))
                                       | ($urandom_range(1) << 8));
      write_reg(psb_pkg::CSR_SPRITE_WIDTH, pick_size() | ($urandom_range(1) << 8));
      write_reg(psb_pkg::CSR_SPRITE_HEIGHT, pick_size() | ($urandom_range(1) << 8));
      write_reg(psb_pkg::CSR_SCALE, s | ($urandom_range(31) << SCALE_W));
      if ($urandom_range(3) == 0)
         write_reg($urandom_range(psb_pkg::CSR_SCALE + 1, (1 << CSR_IDX_W) - 1),
                   $urandom_range(511));
   endtask

   task automatic test_reset_defaults();
      send_code(8'h00);
      send_code(8'hFF);
      send_code(8'h3C);
      send_code(8'h7F);
      send_code(8'h80);
   endtask

   task automatic test_scale_extremes();
      set_sprite(0, 0, 2, 2, 0);
      send_code(8'hE0);
      send_code(8'h55);
      set_sprite(5, 7, 2, 2, 15);
      send_code(8'hAA);
   endtask

   task automatic test_far_corner();
      set_sprite(319, 239, 255, 255, 8);
      send_code(8'hF6);
      send_code(8'h01);
   endtask

   task automatic test_zero_size();
      set_sprite(100, 50, 0, 0, 2);
      repeat (3) send_code(pick_code());
   endtask

   task automatic test_shrink_size();
      set_sprite(10, 20, 4, 4, 1);
      repeat (6) send_code(pick_code());
      wait_idle();
      write_reg(psb_pkg::CSR_SPRITE_HEIGHT, 2);
      send_code(8'h13);
      wait_idle();
      write_reg(psb_pkg::CSR_SPRITE_WIDTH, 1);
      repeat (2) send_code(pick_code());
   endtask

   task automatic test_unused_index();
      wait_idle();
      for (int i = psb_pkg::CSR_SCALE + 1; i < (1 << CSR_IDX_W); i++) write_reg(i, 'h1FF);
      send_code(8'hAD);
   endtask

   task automatic test_random_phases();
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         randomise_sprite();
         case (p % 4)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 57; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 57; end
            default: begin sender_idle_pct = 25; receiver_stall_pct = 25; end
         endcase
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // sender pauses mid-phase until every write is out
            if (p % 3 == 1 && i == PHASE_ITEMS / 2) wait_drained();
            send_code(pick_code());
         end
      end
   endtask

   task automatic test_backpressure();
      set_sprite($urandom_range(319), $urandom_range(239), 3, 3, 2);
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_left      = HOLD_OFF_LONG;
      repeat (16) send_code(pick_code());
   endtask

   task automatic test_address_wrap();
      set_sprite(319, 239, 4, 255, 8);
      sender_idle_pct    = 25;
      receiver_stall_pct = 25;
      repeat (30) send_code(pick_code());
   endtask

   initial begin
      reset              = 1'b1;
      csr_we             = 1'b0;
      csr_index          = '0;
      csr_wdata          = '0;
      req_tvalid         = 1'b0;
      req_tdata          = '0;
      rsp_tready         = 1'b0;
      sender_idle_pct    = 0;
      receiver_stall_pct = 0;
      hold_off_left      = 0;
      errors             = 0;
      quiet_cycles       = 0;
      codes_sent         = 0;
      writes_checked     = 0;
      off_frame_writes   = 0;
      wrapped_addresses  = 0;
      blank_codes        = 0;
      reg_origin_x       = '0;
      reg_origin_y       = '0;
      reg_width          = SIZE_W'(1);
      reg_height         = SIZE_W'(1);
      reg_scale          = SCALE_W'(1);
      cur_column         = 0;
      cur_row            = 0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_reset_defaults();
      test_scale_extremes();
      test_far_corner();
      test_zero_size();
      test_shrink_size();
      test_unused_index();
      test_backpressure();
      test_random_phases();
      test_address_wrap();

      wait_drained();
      repeat (SETTLE_CYCLES) @(negedge clock);
      while (pending_writes.size() != 0) begin
         report_mismatch("missing write, address", pending_writes[0].address, 0);
         void'(pending_writes.pop_front());
      end
      $display("covered %0d codes and %0d checked writes, scales 0 to 15, all idling modes",
               codes_sent, writes_checked);
      $display("%0d off-frame writes, %0d wrapped addresses, %0d blank codes, %0d mismatches",
               off_frame_writes, wrapped_addresses, blank_codes, errors);
      if (errors == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule

### files.f
design/psb_pkg.sv
design/psb_front.sv
design/psb_fifo.sv
design/psb_back.sv
design/palette_sprite_scaler_blit_top.sv
design/psb_checker.sv
verif/testbench.sv
